// ----- hdl/pfd_pkg.sv -----
// pfd_pkg: shared widths, register indexes, divider handshake structs and helpers
// for the filtered-derivative pid step unit; no dependencies
`timescale 1ns / 1ps

package pfd_pkg;

  // fixed-point format and field widths
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 31;
  localparam int CFG_IDX_W = 3;

  // shared multiplier: signed operands one bit wider than the data
  localparam int OPND_W = DATA_W + 1;
  localparam int PROD_W = 2 * OPND_W;

  // derivative numerator, its magnitude, and the scaled dividend
  localparam int NUM_W  = PROD_W - FRAC_BITS;
  localparam int MAG_W  = NUM_W - 1;
  localparam int DIVD_W = MAG_W + FRAC_BITS;
  localparam int DEN_W  = TIME_W + 2;

  // quotient magnitude is capped at the largest positive data value
  localparam int QUOT_W = DATA_W - 1;
  localparam int QCNT_W = $clog2(QUOT_W);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_FILTER_TAU = 3'd3,
    REG_OUT_LOW    = 3'd4,
    REG_OUT_HIGH   = 3'd5,
    REG_INTEG_LOW  = 3'd6,
    REG_INTEG_HIGH = 3'd7
  } cfg_idx_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  // clamp result
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     hit;
  } clamp_t;

  // low limit tested first, then high limit
  function automatic clamp_t clamp(input logic signed [PROD_W-1:0] v,
                                   input logic signed [DATA_W-1:0] lo,
                                   input logic signed [DATA_W-1:0] hi);
    clamp_t                   r;
    logic signed [PROD_W-1:0] lo_x;
    logic signed [PROD_W-1:0] hi_x;
    lo_x = PROD_W'(lo);
    hi_x = PROD_W'(hi);
    if (v < lo_x) begin
      r.value = lo;
      r.hit   = 1'b1;
    end else if (v > hi_x) begin
      r.value = hi;
      r.hit   = 1'b1;
    end else begin
      r.value = v[DATA_W-1:0];
      r.hit   = 1'b0;
    end
    return r;
  endfunction

  // a - b saturated to the data range
  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] d;
    logic signed [DATA_W-1:0] r;
    d = (DATA_W+1)'(a) - (DATA_W+1)'(b);
    if (d[DATA_W] != d[DATA_W-1]) begin
      r = d[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = d[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- hdl/pfd_sample_if.sv -----
// pfd_sample_if: input channel carrying one control sample
// depends on pfd_pkg for field widths
`timescale 1ns / 1ps

interface pfd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [pfd_pkg::DATA_W-1:0]   measurement;
  logic signed [pfd_pkg::DATA_W-1:0]   target;
  logic        [pfd_pkg::TIME_W-1:0]   step_time;

  modport source (output valid, measurement, target, step_time, input ready);
  modport sink   (input valid, measurement, target, step_time, output ready);
endinterface

// ----- hdl/pfd_result_if.sv -----
// pfd_result_if: output channel carrying the clamped drive and its flag
// depends on pfd_pkg for field widths
`timescale 1ns / 1ps

interface pfd_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pfd_pkg::DATA_W-1:0]   drive;
  logic                                drive_saturated;

  modport source (output valid, drive, drive_saturated, input ready);
  modport sink   (input valid, drive, drive_saturated, output ready);
endinterface

// ----- hdl/pfd_mul.sv -----
// pfd_mul: shared signed multiplier with a registered product
// depends on pfd_pkg for operand and product widths
`timescale 1ns / 1ps

module pfd_mul (
  input  logic                              clk,
  input  logic signed [pfd_pkg::OPND_W-1:0] a,
  input  logic signed [pfd_pkg::OPND_W-1:0] b,
  output logic signed [pfd_pkg::PROD_W-1:0] prod
);

  // one product per cycle, registered
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- hdl/pfd_div.sv -----
// pfd_div: restoring divider, one quotient bit per cycle, magnitude capped
// at the largest positive data value; depends on pfd_pkg
`timescale 1ns / 1ps

module pfd_div (
  input  logic              clk,
  input  logic              rst,
  input  pfd_pkg::div_req_t req,
  output pfd_pkg::div_rsp_t rsp
);

  localparam int HI_W = pfd_pkg::DIVD_W - pfd_pkg::QUOT_W;

  logic                              busy;
  logic                              done;
  logic [pfd_pkg::QCNT_W-1:0]        cnt;
  logic [pfd_pkg::DEN_W-1:0]         den;
  logic [pfd_pkg::DEN_W-1:0]         rem;
  logic [pfd_pkg::QUOT_W-1:0]        low;
  logic [pfd_pkg::QUOT_W-1:0]        quot;

  logic [pfd_pkg::DIVD_W-1:0]        dvd_in;
  logic [HI_W-1:0]                   hi_in;
  logic                              ovf_in;
  logic [pfd_pkg::DEN_W:0]           trial;
  logic                              take;

  // scaled dividend and the overflow test on its top bits
  always_comb begin
    dvd_in = {req.mag, {pfd_pkg::FRAC_BITS{1'b0}}};
    hi_in  = dvd_in[pfd_pkg::DIVD_W-1:pfd_pkg::QUOT_W];
    ovf_in = (hi_in >= HI_W'(req.den));
    trial  = {rem, low[pfd_pkg::QUOT_W-1]};
    take   = (trial >= {1'b0, den});
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den  <= req.den;
        low  <= dvd_in[pfd_pkg::QUOT_W-1:0];
        if (ovf_in) begin
          quot <= '1;
          done <= 1'b1;
        end else begin
          rem  <= hi_in[pfd_pkg::DEN_W-1:0];
          quot <= '0;
          cnt  <= pfd_pkg::QCNT_W'(pfd_pkg::QUOT_W - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        low <= {low[pfd_pkg::QUOT_W-2:0], 1'b0};
        if (take) begin
          rem  <= pfd_pkg::DEN_W'(trial - {1'b0, den});
          quot <= {quot[pfd_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= trial[pfd_pkg::DEN_W-1:0];
          quot <= {quot[pfd_pkg::QUOT_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

// ----- hdl/pid_filtered_derivative_step_unit.sv -----
// pid_filtered_derivative_step_unit: pid step with low-pass filtered derivative,
// sequencer around one shared multiplier and one iterative divider
// depends on pfd_pkg, pfd_sample_if, pfd_result_if, pfd_mul, pfd_div
//
//   port      | kind            | payload
//   ----------+-----------------+---------------------------------------------
//   sample    | valid/ready in  | measurement, target, step_time
//   result    | valid/ready out | drive, drive_saturated
//   cfg_*     | write only      | cfg_index selects one of eight registers
//
// after a transfer an item runs the integral and derivative steps, waits in the
// divider (one quotient bit a cycle) unless the scaled quotient is out of range
// and the divider answers at once, or skips it when filter_tau and step_time are
// both zero, then forms the output; no new sample is taken until it is done.
// the five products go one after another through the single multiplier.
// synchronous reset clears the registers, integral, last measurement and filter.
// a held result stalls only the final step; the next sample is taken meanwhile.
`timescale 1ns / 1ps

module pid_filtered_derivative_step_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pfd_pkg::DATA_W-1:0]           cfg_data,
  pfd_sample_if.sink                           sample,
  pfd_result_if.source                         result
);

  localparam int DW = pfd_pkg::DATA_W;
  localparam int PW = pfd_pkg::PROD_W;
  localparam int OW = pfd_pkg::OPND_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INT_MUL,
    S_INT_ACC,
    S_DER_A,
    S_DER_SUM,
    S_DIV_WAIT,
    S_OUT_P,
    S_OUT_I,
    S_OUT_SUM,
    S_OUT_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic signed [DW-1:0]              gain_p;
  logic signed [DW-1:0]              gain_i;
  logic signed [DW-1:0]              gain_d;
  logic        [pfd_pkg::TIME_W-1:0] filter_tau;
  logic signed [DW-1:0]              out_low;
  logic signed [DW-1:0]              out_high;
  logic signed [DW-1:0]              integ_low;
  logic signed [DW-1:0]              integ_high;

  // controller state
  logic signed [DW-1:0]              integral_acc;
  logic signed [DW-1:0]              last_measurement;
  logic signed [DW-1:0]              filtered_deriv;

  // per-sample working registers
  logic signed [DW-1:0]              meas;
  logic signed [DW-1:0]              err;
  logic        [pfd_pkg::TIME_W-1:0] dt;
  logic signed [PW-1:0]              acc;
  logic                              num_neg;

  // result register
  logic                              res_valid;
  logic signed [DW-1:0]              res_drive;
  logic                              res_sat;

  // datapath wires
  logic signed [OW-1:0]              mul_a;
  logic signed [OW-1:0]              mul_b;
  logic signed [PW-1:0]              prod;
  logic signed [PW-1:0]              prod_f;
  logic signed [PW-1:0]              integ_sum;
  logic signed [pfd_pkg::NUM_W-1:0]  num;
  logic        [pfd_pkg::NUM_W-1:0]  num_abs;
  logic        [pfd_pkg::DEN_W-1:0]  den;
  logic        [DW-1:0]              q_ext;
  logic                              out_free;
  pfd_pkg::clamp_t                   integ_clamp;
  pfd_pkg::clamp_t                   out_clamp;
  pfd_pkg::div_req_t                 div_req;
  pfd_pkg::div_rsp_t                 div_rsp;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      filter_tau <= '0;
      out_low    <= '0;
      out_high   <= '0;
      integ_low  <= '0;
      integ_high <= '0;
    end else if (cfg_we) begin
      unique case (pfd_pkg::cfg_idx_t'(cfg_index))
        pfd_pkg::REG_GAIN_P:     gain_p     <= cfg_data;
        pfd_pkg::REG_GAIN_I:     gain_i     <= cfg_data;
        pfd_pkg::REG_GAIN_D:     gain_d     <= cfg_data;
        pfd_pkg::REG_FILTER_TAU: filter_tau <= cfg_data[pfd_pkg::TIME_W-1:0];
        pfd_pkg::REG_OUT_LOW:    out_low    <= cfg_data;
        pfd_pkg::REG_OUT_HIGH:   out_high   <= cfg_data;
        pfd_pkg::REG_INTEG_LOW:  integ_low  <= cfg_data;
        pfd_pkg::REG_INTEG_HIGH: integ_high <= cfg_data;
      endcase
    end
  end

  // multiplier operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_INT_MUL: begin
        mul_a = {2'b00, dt};
        mul_b = OW'(err);
      end
      S_INT_ACC: begin
        mul_a = OW'(gain_d);
        mul_b = {meas[DW-1], meas} - {last_measurement[DW-1], last_measurement};
      end
      S_DER_A: begin
        mul_a = {1'b0, filter_tau, 1'b0} - {2'b00, dt};
        mul_b = OW'(filtered_deriv);
      end
      S_OUT_P: begin
        mul_a = OW'(gain_p);
        mul_b = OW'(err);
      end
      S_OUT_I: begin
        mul_a = OW'(gain_i);
        mul_b = OW'(integral_acc);
      end
      S_IDLE, S_DER_SUM, S_DIV_WAIT, S_OUT_SUM, S_OUT_DONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pfd_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // scaled product, integral update, derivative numerator and denominator
  always_comb begin
    prod_f      = prod >>> pfd_pkg::FRAC_BITS;
    integ_sum   = prod_f + PW'(integral_acc);
    integ_clamp = pfd_pkg::clamp(integ_sum, integ_low, integ_high);
    num         = pfd_pkg::NUM_W'(acc + prod_f);
    num_abs     = num[pfd_pkg::NUM_W-1] ? pfd_pkg::NUM_W'(-num) : pfd_pkg::NUM_W'(num);
    den         = {1'b0, filter_tau, 1'b0} + {2'b00, dt};
    q_ext       = {1'b0, div_rsp.quot};
    out_clamp   = pfd_pkg::clamp(acc, out_low, out_high);
    out_free    = !res_valid || result.ready;
  end

  // divider request
  always_comb begin
    div_req.start = (state == S_DER_SUM) && (den != '0);
    div_req.mag   = num_abs[pfd_pkg::MAG_W-1:0];
    div_req.den   = den;
  end

  pfd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer, controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      integral_acc     <= '0;
      last_measurement <= '0;
      filtered_deriv   <= '0;
      res_valid        <= 1'b0;
    end else begin
      // result register: loaded on the final step, cleared on its transfer
      if ((state == S_OUT_DONE) && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (sample.valid) begin
            meas  <= sample.measurement;
            dt    <= sample.step_time;
            err   <= pfd_pkg::sat_sub(sample.target, sample.measurement);
            state <= S_INT_MUL;
          end
        end
        S_INT_MUL: begin
          state <= S_INT_ACC;
        end
        S_INT_ACC: begin
          integral_acc <= integ_clamp.value;
          state        <= S_DER_A;
        end
        S_DER_A: begin
          acc   <= prod >>> (pfd_pkg::FRAC_BITS - 1);
          state <= S_DER_SUM;
        end
        S_DER_SUM: begin
          num_neg <= num[pfd_pkg::NUM_W-1];
          if (den == '0) begin
            filtered_deriv <= '0;
            state          <= S_OUT_P;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            filtered_deriv <= num_neg ? $signed(q_ext) : -$signed(q_ext);
            state          <= S_OUT_P;
          end
        end
        S_OUT_P: begin
          state <= S_OUT_I;
        end
        S_OUT_I: begin
          acc   <= prod_f;
          state <= S_OUT_SUM;
        end
        S_OUT_SUM: begin
          acc   <= acc + prod_f + PW'(filtered_deriv);
          state <= S_OUT_DONE;
        end
        S_OUT_DONE: begin
          if (out_free) begin
            res_drive        <= out_clamp.value;
            res_sat          <= out_clamp.hit;
            last_measurement <= meas;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign sample.ready           = (state == S_IDLE);
  assign result.valid           = res_valid;
  assign result.drive           = res_drive;
  assign result.drive_saturated = res_sat;

endmodule

// ----- hdl/pfd_checker.sv -----
// pfd_checker: port-level checks on the pid step unit, with its bind
// depends on pid_filtered_derivative_step_unit and its channel interfaces
`timescale 1ns / 1ps

module pfd_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pfd_pkg::DATA_W-1:0] drive,
  input logic                              drive_saturated
);

  // after reset the unit is idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("unit not idle after reset");

  // a sample transfer makes the unit busy, so it does not take a new sample straight away
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("unit ready again too soon after a sample transfer");

  // a new result appears only as the unit returns to idle
  a_result_ends_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result raised outside the end of a step");

  // a stalled result holds its value
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(drive_saturated))
    else $error("stalled result changed");

endmodule

bind pid_filtered_derivative_step_unit pfd_checker u_pfd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (sample.valid),
  .in_ready        (sample.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .drive           (result.drive),
  .drive_saturated (result.drive_saturated)
);
